### sv/vlr_pkg.sv
// Shared types and constants of the voxel line rasterizer.
package vlr_pkg;

  localparam int unsigned CubeEdgeDefault = 10;
  localparam int unsigned CoordW          = 6;
  localparam int unsigned DistW           = 6;
  localparam int unsigned RemW            = 7;
  localparam int unsigned PosW            = 9;
  localparam int unsigned BitOffset       = 2;
  localparam int unsigned MaxResults      = 48;
  localparam int unsigned CountW          = 6;
  localparam int unsigned NumAxes         = 3;
  localparam int unsigned InDataW         = 40;
  localparam int unsigned OutDataW        = 16;

  // Per-axis walker state: current coordinate, rounding remainder,
  // absolute axis distance and step direction.
  typedef struct packed {
    logic signed [CoordW-1:0] coord;
    logic [RemW-1:0]          rem;
    logic [DistW-1:0]         mag;
    logic                     neg;
  } axis_t;

  typedef struct packed {
    logic [3:0] layer;
    logic [3:0] byte_index;
    logic [2:0] bit_index;
  } voxel_t;

endpackage

### sv/vlr_step_unit.sv
// Shared remainder step unit: advances one axis of the line walker by one point.
module vlr_step_unit import vlr_pkg::*; (
  input  axis_t           axis_i,
  input  logic [RemW-1:0] twice_len_i,
  output axis_t           axis_o
);

  logic [RemW:0] sum;
  logic          wrap;

  // The remainder tracks (2*|d|*i + len) mod (2*len); since |d| <= len, the
  // rounded quotient grows by at most one per point.
  assign sum  = {1'b0, axis_i.rem} + {1'b0, axis_i.mag, 1'b0};
  assign wrap = (sum >= {1'b0, twice_len_i});

  always_comb begin
    axis_o = axis_i;
    if (wrap) begin
      axis_o.rem   = RemW'(sum - {1'b0, twice_len_i});
      axis_o.coord = axis_i.neg ? axis_i.coord - CoordW'(1) : axis_i.coord + CoordW'(1);
    end else begin
      axis_o.rem = sum[RemW-1:0];
    end
  end

endmodule

### sv/vlr_voxel_map.sv
// Visibility test and framebuffer address mapping of one voxel.
module vlr_voxel_map import vlr_pkg::*; #(
  parameter int unsigned CUBE_EDGE = CubeEdgeDefault
) (
  input  logic signed [CoordW-1:0] x_i,
  input  logic signed [CoordW-1:0] y_i,
  input  logic signed [CoordW-1:0] z_i,
  output logic                     visible_o,
  output voxel_t                   voxel_o
);

  localparam logic [CoordW-1:0] EdgeLim = CoordW'(CUBE_EDGE);

  logic [PosW-1:0] pos;

  function automatic logic in_cube(logic signed [CoordW-1:0] c);
    return !c[CoordW-1] && ($unsigned(c) < EdgeLim);
  endfunction

  assign visible_o = in_cube(x_i) && in_cube(y_i) && in_cube(z_i);

  // Only meaningful for visible voxels, where every coordinate fits in four bits.
  assign pos = PosW'(y_i[3:0]) * PosW'(CUBE_EDGE) + PosW'(z_i[3:0]) + PosW'(BitOffset);

  assign voxel_o.layer      = x_i[3:0];
  assign voxel_o.byte_index = pos[6:3];
  assign voxel_o.bit_index  = pos[2:0];

endmodule

### sv/voxel_line_rasterizer_unit.sv
// Top level of the voxel line rasterizer: command sequencer and output stage.
// A command carries two signed endpoints and a skip flag; the block walks the
// line and emits one framebuffer write (layer, byte, bit) per visible voxel,
// with tlast on the final write, and none at all when nothing is visible.
// After the command transfer the block stays busy until it is back in idle,
// longer under output stalls; len is the largest axis distance (up to 63):
// the start and end voxels each have their own state (passed over when the
// endpoints are skipped), each interior point takes three passes through the
// single shared remainder step unit, one per axis, and then a state that maps
// and queues the voxel, and a final flush state releases the held write.
// The next command is taken once the block is back in idle. One write is held
// back until the next one is known so that tlast can be set; at most 48 writes
// are produced.
module voxel_line_rasterizer_unit import vlr_pkg::*; #(
  parameter int unsigned CUBE_EDGE = CubeEdgeDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // start_x[5:0], start_y[11:6], start_z[17:12], end_x[23:18], end_y[29:24],
  // end_z[35:30], zero fill[39:36]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // skip_endpoints
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // layer[3:0], byte_index[7:4], bit_index[10:8], zero fill[15:11]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PT_A,
    S_PT_B,
    S_AX_X,
    S_AX_Y,
    S_AX_Z,
    S_PT_I,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;
  axis_t  axis_q [NumAxes];
  axis_t  axis_d [NumAxes];
  logic signed [CoordW-1:0] end_q [NumAxes];
  logic signed [CoordW-1:0] end_d [NumAxes];
  logic [DistW-1:0]  len_q, len_d;
  logic [DistW-1:0]  idx_q, idx_d;
  logic [CountW-1:0] count_q, count_d;
  voxel_t pend_q, pend_d;
  logic   pend_valid_q, pend_valid_d;
  voxel_t out_voxel_q, out_voxel_d;
  logic   out_last_q, out_last_d;
  logic   out_valid_q, out_valid_d;

  logic signed [CoordW-1:0] in_a [NumAxes];
  logic signed [CoordW-1:0] in_b [NumAxes];
  logic signed [CoordW:0]   diff [NumAxes];
  logic [DistW-1:0]         ax_mag [NumAxes];
  logic [DistW-1:0]         len_new;
  logic [DistW-1:0]         len_xy;

  logic [1:0]               ax_sel;
  axis_t                    step_in, step_out;
  logic signed [CoordW-1:0] pt_x, pt_y, pt_z;
  logic                     pt_visible;
  voxel_t                   pt_voxel;
  logic                     take, room, advance;

  assign in_a[0] = s_axis_tdata_i[5:0];
  assign in_a[1] = s_axis_tdata_i[11:6];
  assign in_a[2] = s_axis_tdata_i[17:12];
  assign in_b[0] = s_axis_tdata_i[23:18];
  assign in_b[1] = s_axis_tdata_i[29:24];
  assign in_b[2] = s_axis_tdata_i[35:30];

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      diff[k]   = {in_b[k][CoordW-1], in_b[k]} - {in_a[k][CoordW-1], in_a[k]};
      ax_mag[k] = diff[k][CoordW] ? DistW'(-diff[k]) : DistW'(diff[k]);
    end
  end

  assign len_xy  = (ax_mag[1] > ax_mag[0]) ? ax_mag[1] : ax_mag[0];
  assign len_new = (ax_mag[2] > len_xy) ? ax_mag[2] : len_xy;

  always_comb begin
    case (state_q)
      S_AX_Y:  ax_sel = 2'd1;
      S_AX_Z:  ax_sel = 2'd2;
      default: ax_sel = 2'd0;
    endcase
  end

  assign step_in = axis_q[ax_sel];

  vlr_step_unit u_step (
    .axis_i      (step_in),
    .twice_len_i ({len_q, 1'b0}),
    .axis_o      (step_out)
  );

  // Before any step the walker coordinates equal the start point.
  assign pt_x = (state_q == S_PT_B) ? end_q[0] : axis_q[0].coord;
  assign pt_y = (state_q == S_PT_B) ? end_q[1] : axis_q[1].coord;
  assign pt_z = (state_q == S_PT_B) ? end_q[2] : axis_q[2].coord;

  vlr_voxel_map #(
    .CUBE_EDGE (CUBE_EDGE)
  ) u_map (
    .x_i       (pt_x),
    .y_i       (pt_y),
    .z_i       (pt_z),
    .visible_o (pt_visible),
    .voxel_o   (pt_voxel)
  );

  assign take    = pt_visible && (count_q < CountW'(MaxResults));
  assign room    = !out_valid_q || m_axis_tready_i;
  assign advance = !take || !pend_valid_q || room;

  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    end_d        = end_q;
    len_d        = len_q;
    idx_d        = idx_q;
    count_d      = count_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_voxel_d  = out_voxel_q;
    out_last_d   = out_last_q;
    out_valid_d  = m_axis_tready_i ? 1'b0 : out_valid_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          for (int k = 0; k < NumAxes; k++) begin
            axis_d[k].coord = in_a[k];
            axis_d[k].rem   = RemW'(len_new);
            axis_d[k].mag   = ax_mag[k];
            axis_d[k].neg   = diff[k][CoordW];
            end_d[k]        = in_b[k];
          end
          len_d        = len_new;
          idx_d        = DistW'(1);
          count_d      = '0;
          pend_valid_d = 1'b0;
          if (!s_axis_tuser_i) begin
            state_d = S_PT_A;
          end else if (len_new > DistW'(1)) begin
            state_d = S_AX_X;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end
      S_PT_A, S_PT_B, S_PT_I: begin
        if (advance) begin
          if (take) begin
            if (pend_valid_q) begin
              out_voxel_d = pend_q;
              out_last_d  = 1'b0;
              out_valid_d = 1'b1;
            end
            pend_d       = pt_voxel;
            pend_valid_d = 1'b1;
            count_d      = count_q + CountW'(1);
          end
          if (state_q == S_PT_A) begin
            state_d = S_PT_B;
          end else if (state_q == S_PT_B) begin
            state_d = (len_q > DistW'(1)) ? S_AX_X : S_FLUSH;
          end else if (idx_q == len_q - DistW'(1)) begin
            state_d = S_FLUSH;
          end else begin
            idx_d   = idx_q + DistW'(1);
            state_d = S_AX_X;
          end
        end
      end
      S_AX_X, S_AX_Y, S_AX_Z: begin
        axis_d[ax_sel] = step_out;
        case (state_q)
          S_AX_X:  state_d = S_AX_Y;
          S_AX_Y:  state_d = S_AX_Z;
          default: state_d = S_PT_I;
        endcase
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (room) begin
          out_voxel_d  = pend_q;
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      len_q        <= '0;
      idx_q        <= '0;
      count_q      <= '0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      len_q        <= len_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q      <= axis_d;
    end_q       <= end_d;
    pend_q      <= pend_d;
    out_voxel_q <= out_voxel_d;
    out_last_q  <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {5'b0, out_voxel_q.bit_index, out_voxel_q.byte_index,
                            out_voxel_q.layer};

endmodule

### sv/vlr_checker.sv
// Port-level checker of the voxel line rasterizer, bound to its top level.
module vlr_checker import vlr_pkg::*; #(
  parameter int unsigned CUBE_EDGE = CubeEdgeDefault
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tlast_o
);

  localparam logic [3:0] LayerLim = 4'(CUBE_EDGE - 1);

  // A command transfer always starts a walk, so the input side closes next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input still ready right after a command transfer");

  // Every emitted write addresses a layer inside the cube and keeps the fill bits clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[3:0] <= LayerLim) && (m_axis_tdata_o[15:11] == 5'b0))
    else $error("voxel write outside the cube or with nonzero fill bits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped before its transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

endmodule

bind voxel_line_rasterizer_unit vlr_checker #(
  .CUBE_EDGE (CUBE_EDGE)
) u_vlr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
